[rtl/lktd_pkg.sv]
// Shared types and constants for the light-key threshold detector.
package lktd_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS      = 12;
	localparam int SMP_W            = 12;
	localparam int TH_W             = SMP_W + 1;
	localparam int CNT_W            = 4;
	localparam int CH_FIELD_W       = 3;
	localparam int KEY_BITS         = 8;
	localparam int CFG_DATA_W       = 12;
	localparam int CFG_IDX_W        = 2;

	localparam logic [SMP_W-1:0] SAMPLE_MASK    = SMP_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [SMP_W-1:0] OFFSET_RESET   = 12'd200;
	localparam logic [CNT_W-1:0] WINDOW_RESET   = 4'd10;
	localparam logic [CNT_W-1:0] MINHITS_RESET  = 4'd10;
	localparam logic [CNT_W-1:0] COUNT_MAX      = 4'd15;

	localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS       = 2'd2;

	localparam logic CMD_CAL = 1'b0;
	localparam logic CMD_DET = 1'b1;

	typedef struct packed {
		logic                  last;
		logic [CH_FIELD_W-1:0] channel;
		logic [SMP_W-1:0]      sample;
	} det_item_t;

endpackage

[rtl/lktd_thresh_mem.sv]
// Per-channel threshold memory with reset-cleared valid bits and registered read.
module lktd_thresh_mem #(
	parameter int DEPTH = lktd_pkg::NUM_CHANNELS_DEF,
	parameter int AW    = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic                            wr_en,
	input  logic [AW-1:0]                   addr,
	input  logic signed [lktd_pkg::TH_W-1:0] wr_data,
	output logic signed [lktd_pkg::TH_W-1:0] rd_data
);
	import lktd_pkg::*;

	logic signed [TH_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]       valid_q;
	logic signed [TH_W-1:0] rd_raw_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

[rtl/lktd_hit_track.sv]
// Hit counters, sweep counter and key mask evaluation for detection words.
module lktd_hit_track #(
	parameter int NUM_CHANNELS = lktd_pkg::NUM_CHANNELS_DEF,
	parameter int AW           = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid,
	input  logic                               step,
	input  lktd_pkg::det_item_t                item,
	input  logic signed [lktd_pkg::TH_W-1:0]    threshold,
	input  logic [lktd_pkg::CNT_W-1:0]          window_len,
	input  logic [lktd_pkg::CNT_W-1:0]          min_hits,
	output logic                               emit,
	output logic [lktd_pkg::KEY_BITS-1:0]       key_mask
);
	import lktd_pkg::*;

	logic [CNT_W-1:0] cnt_q    [NUM_CHANNELS];
	logic [CNT_W-1:0] cnt_next [NUM_CHANNELS];
	logic [CNT_W-1:0] sweep_q;
	logic [CNT_W-1:0] sweep_next;
	logic [CNT_W-1:0] need;
	logic [AW-1:0]    ch_idx;
	logic             hit;

	assign ch_idx = AW'({{(8 - CH_FIELD_W){1'b0}}, item.channel});
	assign hit    = $signed({1'b0, item.sample}) < threshold;

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			cnt_next[i] = cnt_q[i];
			if (ch_idx == AW'(i) && hit && cnt_q[i] != COUNT_MAX) begin
				cnt_next[i] = cnt_q[i] + 1'b1;
			end
		end
	end

	assign sweep_next = (sweep_q != COUNT_MAX) ? sweep_q + 1'b1 : sweep_q;
	assign need       = (window_len == '0) ? CNT_W'(1) : window_len;
	assign emit       = valid && item.last && (sweep_next >= need);

	generate
		for (genvar i = 0; i < KEY_BITS; i++) begin : g_mask
			if (i < NUM_CHANNELS) begin : g_on
				assign key_mask[i] = cnt_next[i] >= min_hits;
			end else begin : g_off
				assign key_mask[i] = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (step) begin
			if (emit) begin
				sweep_q <= '0;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					cnt_q[i] <= '0;
				end
			end else begin
				if (item.last) begin
					sweep_q <= sweep_next;
				end
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					cnt_q[i] <= cnt_next[i];
				end
			end
		end
	end

endmodule

[rtl/light_key_threshold_detect.sv]
// Top level of the light-key threshold detector: input stage, config registers, output register.
//
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser[0] is the
// command (0 calibrate, 1 detect), s_tuser[3:1] the channel; s_tdata[11:0]
// the converter sample. A calibration word writes the channel's threshold
// (sample minus ambient_offset) into the threshold memory in the cycle it is
// accepted. A detection word reads that memory in the accept cycle; in the
// compare stage that follows, the block compares, updates the hit counter
// and, on the last channel, the sweep counter. When a window closes, the key
// mask is loaded into the output register as the closing word leaves the
// compare stage and is shown on m_tdata[7:0] at once, raising m_tvalid.
// One word is accepted per cycle while s_tready is high; the threshold memory
// takes one read or one write per cycle. While m_tvalid is held by a stalled
// receiver, words that close no window keep flowing; a word that closes
// another window waits in the compare stage and s_tready drops until the
// output register frees. Reset clears counters, threshold valid bits and the
// config registers to their defaults (offset 200, window 10 sweeps, 10 hits).
// Config writes on cfg_we/cfg_index/cfg_data are registered; index 3 is ignored.
module light_key_threshold_detect #(
	parameter int NUM_CHANNELS = lktd_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,  // sample[11:0], zero pad
	input  logic [3:0]                          s_tuser,  // cmd[0], channel[3:1]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,  // key_mask[7:0]
	input  logic                                cfg_we,
	input  logic [lktd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lktd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import lktd_pkg::*;

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [SMP_W-1:0]       offset_q;
	logic [CNT_W-1:0]       window_q;
	logic [CNT_W-1:0]       min_hits_q;

	logic                   in_cmd;
	logic [CH_FIELD_W-1:0]  in_ch;
	logic [SMP_W-1:0]       in_smp;
	logic [7:0]             ch_ext;
	logic                   in_range;
	logic                   accept;
	logic [AW-1:0]          addr;
	logic signed [TH_W-1:0] th_wr;
	logic signed [TH_W-1:0] th_rd;

	logic                   valid_s1;
	det_item_t              item_s1;
	det_item_t              item_in;
	logic                   emit;
	logic                   go_s1;
	logic [KEY_BITS-1:0]    mask;

	logic                   out_valid_q;
	logic [KEY_BITS-1:0]    out_mask_q;

	assign in_cmd   = s_tuser[0];
	assign in_ch    = s_tuser[3:1];
	assign in_smp   = s_tdata[SMP_W-1:0] & SAMPLE_MASK;
	assign ch_ext   = {{(8 - CH_FIELD_W){1'b0}}, in_ch};
	assign in_range = ch_ext < 8'(NUM_CHANNELS);
	assign addr     = AW'(ch_ext);
	assign th_wr    = $signed({1'b0, in_smp}) - $signed({1'b0, offset_q});

	assign item_in.last    = (ch_ext == 8'(NUM_CHANNELS - 1));
	assign item_in.channel = in_ch;
	assign item_in.sample  = in_smp;

	assign go_s1    = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= OFFSET_RESET;
			window_q   <= WINDOW_RESET;
			min_hits_q <= MINHITS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AMBIENT_OFFSET: offset_q   <= cfg_data[SMP_W-1:0];
				REG_WINDOW_LEN:     window_q   <= cfg_data[CNT_W-1:0];
				REG_MIN_HITS:       min_hits_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	lktd_thresh_mem #(
		.DEPTH (NUM_CHANNELS),
		.AW    (AW)
	) u_thresh_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range && in_cmd == CMD_DET),
		.wr_en   (accept && in_range && in_cmd == CMD_CAL),
		.addr    (addr),
		.wr_data (th_wr),
		.rd_data (th_rd)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= accept && in_range && in_cmd == CMD_DET;
		end
	end

	lktd_hit_track #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.AW           (AW)
	) u_hit_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.step       (go_s1),
		.item       (item_s1),
		.threshold  (th_rd),
		.window_len (window_q),
		.min_hits   (min_hits_q),
		.emit       (emit),
		.key_mask   (mask)
	);

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			out_mask_q <= mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_mask_q;

endmodule

[tb/tb_light_key_threshold_detect.sv]
`timescale 1ns / 1ps
// Testbench for light_key_threshold_detect: a directed table, then random sweeps checked against a model.
module tb_light_key_threshold_detect;
	import lktd_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int LAST_CH        = NUM_CHANNELS_DEF - 1;
	localparam int SETTLE_CYCLES  = 6;
	localparam int HOLD_CYCLES    = 400;
	localparam int STALL_LIMIT    = 3000;
	localparam int PHASE_COUNT    = 10;
	localparam int PHASE_WORDS    = 130;
	localparam int PRESSURE_PHASE = 5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic                  cmd;
		logic [CH_FIELD_W-1:0] channel;
		logic [CFG_DATA_W-1:0] value;
		logic                  typed;
		logic [KEY_BITS-1:0]   mask;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;  // sample[11:0], zero pad
	logic [3:0]            s_tuser;  // cmd[0], channel[3:1]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;  // key_mask[7:0]
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic signed [TH_W-1:0] th_mem [NUM_CHANNELS_DEF];
	logic [CNT_W-1:0]       hit_cnt [NUM_CHANNELS_DEF];
	logic [CNT_W-1:0]       sweep_cnt;
	logic [SMP_W-1:0]       ofs_reg;
	logic [CNT_W-1:0]       win_reg;
	logic [CNT_W-1:0]       min_hits_reg;
	logic [KEY_BITS-1:0]    key_mask_due [$];
	logic [KEY_BITS-1:0]    want_mask;

	dir_row_t dir_rows [$];

	int ph_ofs [PHASE_COUNT] = '{0, 4095, 200, -1, -1, -1, -1, 100, -1, -1};
	int ph_win [PHASE_COUNT] = '{1, 15, 10, -1, 0, 1, -1, 2, -1, -1};
	int ph_min [PHASE_COUNT] = '{1, 15, 10, -1, 0, -1, -1, 1, -1, -1};

	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	int words_sent   = 0;
	int errors       = 0;
	int stall_cycles = 0;
	int hold_left    = 0;
	bit hold_armed   = 1'b0;

	light_key_threshold_detect i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic bit scan_sample(input logic cmd, input logic [CH_FIELD_W-1:0] ch,
		input logic [SMP_W-1:0] smp, output logic [KEY_BITS-1:0] mask);
		logic [CNT_W-1:0] need;
		int i;
		mask = '0;
		if (cmd == CMD_CAL) begin
			th_mem[ch] = $signed({1'b0, smp}) - $signed({1'b0, ofs_reg});
			return 1'b0;
		end
		if ($signed({1'b0, smp & SAMPLE_MASK}) < th_mem[ch] && hit_cnt[ch] != COUNT_MAX)
			hit_cnt[ch] = hit_cnt[ch] + 1'b1;
		if (ch != LAST_CH)
			return 1'b0;
		if (sweep_cnt != COUNT_MAX)
			sweep_cnt = sweep_cnt + 1'b1;
		need = (win_reg == '0) ? CNT_W'(1) : win_reg;
		if (sweep_cnt < need)
			return 1'b0;
		for (i = 0; i < NUM_CHANNELS_DEF && i < KEY_BITS; i++)
			mask[i] = (hit_cnt[i] >= min_hits_reg);
		for (i = 0; i < NUM_CHANNELS_DEF; i++)
			hit_cnt[i] = '0;
		sweep_cnt = '0;
		return 1'b1;
	endfunction

	function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_AMBIENT_OFFSET: ofs_reg = val[SMP_W-1:0];
			REG_WINDOW_LEN:     win_reg = val[CNT_W-1:0];
			REG_MIN_HITS:       min_hits_reg = val[CNT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		dir_rows.push_back('{ROW_WRITE, idx, 1'b0, '0, val, 1'b0, '0});
	endfunction

	function automatic void add_word(input logic cmd, input logic [CH_FIELD_W-1:0] ch,
		input logic [SMP_W-1:0] smp, input logic typed, input logic [KEY_BITS-1:0] mask);
		dir_rows.push_back('{ROW_WORD, '0, cmd, ch, CFG_DATA_W'(smp), typed, mask});
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: key mask mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic send_word(input logic cmd, input logic [CH_FIELD_W-1:0] ch,
		input logic [SMP_W-1:0] smp, input logic typed, input logic [KEY_BITS-1:0] typed_mask);
		logic [KEY_BITS-1:0] mask;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= 16'(smp);
		s_tuser  <= {ch, cmd};
		do @(posedge clk); while (!s_tready);
		if (scan_sample(cmd, ch, smp, mask))
			key_mask_due.push_back(typed ? typed_mask : mask);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (key_mask_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int target);
		int stop_at;
		int roll;
		int c;
		int k;
		logic [KEY_BITS-1:0]   press;
		logic [CH_FIELD_W-1:0] ch;
		stop_at = words_sent + target;
		press = KEY_BITS'($urandom);
		while (words_sent < stop_at) begin
			roll = $urandom_range(99);
			if ($urandom_range(99) < 20)
				press = KEY_BITS'($urandom);
			if (roll < 8) begin
				for (c = 0; c < NUM_CHANNELS_DEF; c++)
					send_word(CMD_CAL, CH_FIELD_W'(c), SMP_W'($urandom_range(1500, 4095)),
						1'b0, '0);
			end else if (roll < 11) begin
				ch = CH_FIELD_W'($urandom);
				for (k = 0; k < 20; k++)
					send_word(CMD_DET, ch, SMP_W'($urandom_range(300)), 1'b0, '0);
			end else if (roll < 20) begin
				for (k = 0; k < 4; k++)
					send_word(1'($urandom), CH_FIELD_W'($urandom), SMP_W'($urandom), 1'b0, '0);
			end else begin
				for (c = 0; c < NUM_CHANNELS_DEF; c++)
					if ($urandom_range(99) >= 5)
						send_word(CMD_DET, CH_FIELD_W'(c),
							press[c] ? SMP_W'($urandom_range(400)) : SMP_W'($urandom),
							1'b0, '0);
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_armed) begin
			hold_armed = 1'b0;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (arst_n && m_tvalid && m_tready) begin
			if (key_mask_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word %02h", m_tdata));
			end else begin
				want_mask = key_mask_due.pop_front();
				if (m_tdata !== want_mask)
					report_mismatch($sformatf("got %02h, want %02h", m_tdata, want_mask));
			end
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int p;
		int i;
		dir_row_t row;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		ofs_reg      = OFFSET_RESET;
		win_reg      = WINDOW_RESET;
		min_hits_reg = MINHITS_RESET;
		sweep_cnt    = '0;
		for (i = 0; i < NUM_CHANNELS_DEF; i++) begin
			th_mem[i]  = '0;
			hit_cnt[i] = '0;
		end

		add_write(REG_WINDOW_LEN, 12'd1);
		add_write(REG_AMBIENT_OFFSET, 12'd0);
		add_write(REG_MIN_HITS, 12'd1);
		add_word(CMD_DET, 3'd7, 12'd0, 1'b1, 8'h00);
		add_word(CMD_CAL, 3'd7, 12'd4095, 1'b0, '0);
		add_word(CMD_DET, 3'd7, 12'd4094, 1'b1, 8'h80);
		add_word(CMD_DET, 3'd7, 12'd4095, 1'b1, 8'h00);
		add_word(CMD_DET, 3'd0, 12'd4095, 1'b0, '0);
		add_write(REG_AMBIENT_OFFSET, 12'd4095);
		add_word(CMD_CAL, 3'd0, 12'd0, 1'b0, '0);
		add_word(CMD_DET, 3'd0, 12'd0, 1'b0, '0);
		add_word(CMD_DET, 3'd7, 12'd0, 1'b1, 8'h80);
		add_write(REG_MIN_HITS, 12'd0);
		add_word(CMD_DET, 3'd3, 12'd4095, 1'b0, '0);
		add_word(CMD_DET, 3'd7, 12'd4095, 1'b1, 8'hFF);
		add_write(REG_SPARE, 12'hFFF);
		add_write(REG_WINDOW_LEN, 12'd0);
		add_word(CMD_DET, 3'd7, 12'd4095, 1'b1, 8'hFF);
		add_write(REG_MIN_HITS, 12'hFF2);
		add_write(REG_WINDOW_LEN, 12'h003);
		add_write(REG_AMBIENT_OFFSET, 12'h800);
		add_word(CMD_CAL, 3'd1, 12'd4095, 1'b0, '0);
		add_word(CMD_DET, 3'd1, 12'd2046, 1'b0, '0);
		add_word(CMD_DET, 3'd7, 12'd0, 1'b0, '0);
		add_word(CMD_DET, 3'd1, 12'd2047, 1'b0, '0);
		add_word(CMD_DET, 3'd7, 12'd4095, 1'b0, '0);
		add_word(CMD_CAL, 3'd7, 12'd0, 1'b0, '0);
		add_word(CMD_DET, 3'd1, 12'd0, 1'b0, '0);
		add_word(CMD_DET, 3'd7, 12'd0, 1'b0, '0);
		add_word(CMD_DET, 3'd2, 12'd0, 1'b0, '0);
		add_word(CMD_DET, 3'd7, 12'd4095, 1'b0, '0);
		add_word(CMD_DET, 3'd7, 12'd4095, 1'b0, '0);
		add_write(REG_WINDOW_LEN, 12'd1);
		add_word(CMD_DET, 3'd7, 12'd4095, 1'b0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 11;
		rx_idle_pct = 62;
		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			if (row.kind == ROW_WRITE)
				write_reg(row.index, row.value);
			else
				send_word(row.cmd, row.channel, row.value[SMP_W-1:0], row.typed, row.mask);
		end

		for (p = 0; p < PHASE_COUNT; p++) begin
			tx_idle_pct = (p < 4) ? 11 : (p < 7) ? 62 : 0;
			rx_idle_pct = (p < 4) ? 62 : (p < 7) ? 11 : 0;
			write_reg(REG_AMBIENT_OFFSET,
				(ph_ofs[p] < 0) ? CFG_DATA_W'($urandom) : CFG_DATA_W'(ph_ofs[p]));
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
			write_reg(REG_WINDOW_LEN,
				(ph_win[p] < 0) ? CFG_DATA_W'($urandom_range(15)) : CFG_DATA_W'(ph_win[p]));
			write_reg(REG_MIN_HITS,
				(ph_min[p] < 0) ? CFG_DATA_W'($urandom_range(15)) : CFG_DATA_W'(ph_min[p]));
			if (p == PRESSURE_PHASE) begin
				@(posedge clk);
				hold_armed = 1'b1;
				@(negedge clk);
			end
			random_phase(PHASE_WORDS);
		end

		drain_results();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
